@@ src/rcsa_pkg.sv @@
// Shared types, widths and constants for the ratiometric current-sensor averager.
// Used by every module of the block; depends on nothing else.
package rcsa_pkg;

  localparam int ADC_W  = 10;
  localparam int CNT_W  = 16;
  localparam int TIME_W = 32;
  localparam int SUM_W  = 32;
  localparam int AVG_W  = 16;
  localparam int SUP_W  = ADC_W + 1;
  localparam int DIFF_W = ADC_W + 2;
  localparam int MAG_W  = ADC_W + 1;
  localparam int K_W    = 17;
  localparam int PROD_W = MAG_W + K_W;
  localparam int DIV_W  = 32;
  localparam int DVS_W  = 16;
  localparam int STEP_W = 5;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_SENSOR_MODEL = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FEEDBACK_EN  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_SAMPLES      = 2'd2;
  localparam logic [IDX_W-1:0] CFG_INTERVAL     = 2'd3;

  localparam logic [1:0] MODEL_100MV = 2'd0;
  localparam logic [1:0] MODEL_37MV  = 2'd1;

  localparam logic [K_W-1:0] K_MODEL0 = 17'd16500;
  localparam logic [K_W-1:0] K_MODEL1 = 17'd44595;
  localparam logic [K_W-1:0] K_MODEL2 = 17'd89189;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_STATUS = 1'b1;

  localparam logic CAUSE_PERIODIC = 1'b0;
  localparam logic CAUSE_STATUS   = 1'b1;

  typedef struct packed {
    logic [1:0]        model;
    logic              fb_en;
    logic [CNT_W-1:0]  samples;
    logic [TIME_W-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic              is_status;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [SUP_W-1:0]  sup;
    logic [K_W-1:0]    k;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [K_W-1:0] k_of(input logic [1:0] model);
    logic [K_W-1:0] k;
    unique case (model)
      MODEL_100MV: k = K_MODEL0;
      MODEL_37MV:  k = K_MODEL1;
      default:     k = K_MODEL2;
    endcase
    return k;
  endfunction

endpackage

@@ src/rcsa_front.sv @@
// Front end: classifies incoming transactions and queues them for the back end.
// Depends on rcsa_pkg for the item and configuration types.
module rcsa_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rcsa_pkg::cfg_t           cfg,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_action,
  input  logic [9:0]               in_adc_input,
  input  logic [9:0]               in_adc_supply,
  input  logic [31:0]              in_now_ms,
  output logic                     q_valid,
  output rcsa_pkg::item_t          q_item,
  input  logic                     q_pop
);
  import rcsa_pkg::*;

  item_t             item;
  logic [SUP_W-1:0]  sup;
  logic [DIFF_W-1:0] diff;
  logic              push_ok;

  item_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  always_comb begin
    if (cfg.fb_en) begin
      sup = (in_adc_supply == '0) ? SUP_W'(1) : SUP_W'(in_adc_supply);
    end else begin
      sup = SUP_W'(1) << ADC_W;
    end
    diff = {1'b0, in_adc_input, 1'b0} - DIFF_W'(sup);
    item.is_status = (in_action == ACTION_STATUS);
    item.neg = diff[DIFF_W-1];
    item.mag = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    item.sup = sup;
    item.k = k_of(cfg.model);
    item.now = in_now_ms;
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/rcsa_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on rcsa_pkg for the request and response types.
module rcsa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rcsa_pkg::div_req_t req,
  output rcsa_pkg::div_rsp_t rsp
);
  import rcsa_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(rem_sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ src/rcsa_back.sv @@
// Back end: converts, accumulates and averages samples and issues reports.
// Depends on rcsa_pkg and drives the shared divider through its request struct.
module rcsa_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rcsa_pkg::cfg_t           cfg,
  input  logic                     q_valid,
  input  rcsa_pkg::item_t          q_item,
  output logic                     q_pop,
  output rcsa_pkg::div_req_t       div_req,
  input  rcsa_pkg::div_rsp_t       div_rsp,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [15:0]       out_averaged_current_ma,
  output logic                     out_report_cause
);
  import rcsa_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_DIV1  = 4'd2;
  localparam logic [3:0] ST_WAIT1 = 4'd3;
  localparam logic [3:0] ST_ACC   = 4'd4;
  localparam logic [3:0] ST_DIV2  = 4'd5;
  localparam logic [3:0] ST_WAIT2 = 4'd6;
  localparam logic [3:0] ST_AVG   = 4'd7;
  localparam logic [3:0] ST_RPT   = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  logic [3:0]        state_r, state_nxt;
  item_t             item_r, item_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [AVG_W-1:0]  avg_r, avg_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic              cause_r, cause_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0]  out_avg_r, out_avg_nxt;
  logic              out_cause_r, out_cause_nxt;

  logic [SUM_W+1:0]  q_ext;
  logic [SUM_W+1:0]  cur_ext;
  logic [SUM_W+1:0]  sum_wide;
  logic [SUM_W-1:0]  sum_sat;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  n_eff;
  logic              blk_end;
  logic [DIV_W-1:0]  sum_abs;
  logic [TIME_W-1:0] deadline;
  logic              slot_free;

  always_comb begin
    n_eff = (cfg.samples == '0) ? CNT_W'(1) : cfg.samples;
    q_ext = (SUM_W+2)'(quo_r[PROD_W-1:0]);
    cur_ext = item_r.neg ? -q_ext : q_ext;
    sum_wide = {{2{sum_r[SUM_W-1]}}, sum_r} + cur_ext;
    if (sum_wide[SUM_W+1:SUM_W-1] == 3'b000 || sum_wide[SUM_W+1:SUM_W-1] == 3'b111) begin
      sum_sat = sum_wide[SUM_W-1:0];
    end else if (sum_wide[SUM_W+1]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
    cnt_inc = cnt_r + CNT_W'(1);
    blk_end = (cnt_inc == '0) || (cnt_inc >= n_eff);
    sum_abs = sum_r[SUM_W-1] ? DIV_W'(-sum_r) : DIV_W'(sum_r);
    deadline = last_r + cfg.interval;
    slot_free = !out_valid_r || out_pop;
  end

  always_comb begin
    div_req.start = (state_r == ST_DIV1) || (state_r == ST_DIV2);
    if (state_r == ST_DIV1) begin
      div_req.dividend = DIV_W'(prod_r);
      div_req.divisor = DVS_W'(item_r.sup);
    end else begin
      div_req.dividend = sum_abs;
      div_req.divisor = n_eff;
    end
  end

  assign q_pop = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    prod_nxt = prod_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    avg_nxt = avg_r;
    last_nxt = last_r;
    cause_nxt = cause_r;
    out_valid_nxt = out_pop ? 1'b0 : out_valid_r;
    out_avg_nxt = out_avg_r;
    out_cause_nxt = out_cause_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          item_nxt = q_item;
          if (q_item.is_status) begin
            cause_nxt = CAUSE_STATUS;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt = PROD_W'(item_r.mag) * PROD_W'(item_r.k);
        state_nxt = ST_DIV1;
      end
      ST_DIV1: begin
        state_nxt = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (div_rsp.done) begin
          quo_nxt = div_rsp.quotient;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_nxt = sum_sat;
        if (blk_end) begin
          cnt_nxt = '0;
          state_nxt = ST_DIV2;
        end else begin
          cnt_nxt = cnt_inc;
          state_nxt = ST_RPT;
        end
      end
      ST_DIV2: begin
        state_nxt = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (div_rsp.done) begin
          quo_nxt = div_rsp.quotient;
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        if (sum_r[SUM_W-1]) begin
          avg_nxt = (quo_r > DIV_W'(32768)) ? 16'h8000 : -AVG_W'(quo_r);
        end else begin
          avg_nxt = (quo_r > DIV_W'(32767)) ? 16'h7FFF : AVG_W'(quo_r);
        end
        sum_nxt = '0;
        state_nxt = ST_RPT;
      end
      ST_RPT: begin
        if (item_r.now > deadline) begin
          last_nxt = item_r.now;
          cause_nxt = CAUSE_PERIODIC;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt = avg_r;
          out_cause_nxt = cause_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      sum_r <= '0;
      avg_r <= '0;
      last_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      avg_r <= avg_nxt;
      last_r <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    prod_r <= prod_nxt;
    quo_r <= quo_nxt;
    cause_r <= cause_nxt;
    out_avg_r <= out_avg_nxt;
    out_cause_r <= out_cause_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_averaged_current_ma = out_avg_r;
  assign out_report_cause = out_cause_r;

endmodule

@@ src/ratiometric_current_sensor_averager_unit.sv @@
// Ratiometric current-sensor averager: configuration registers, front queue,
// back-end sequencer and shared divider. Depends on rcsa_pkg and all rcsa_ modules.
// A status request passes the front queue and the idle and emit states; a sample also
// passes multiply, divide, accumulate and report, plus a second division at block end.
// Throughput: one transaction at a time in the back end; the front queue holds two.
// Reset: synchronous, active low; resets configuration, accumulators, queues and result.
module ratiometric_current_sensor_averager_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_action,
  input  logic [9:0]         in_adc_input,
  input  logic [9:0]         in_adc_supply,
  input  logic [31:0]        in_now_ms,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_averaged_current_ma,
  output logic               out_report_cause
);
  import rcsa_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SENSOR_MODEL: cfg_nxt.model = cfg_wdata[1:0];
        CFG_FEEDBACK_EN:  cfg_nxt.fb_en = cfg_wdata[0];
        CFG_SAMPLES:      cfg_nxt.samples = cfg_wdata[CNT_W-1:0];
        CFG_INTERVAL:     cfg_nxt.interval = cfg_wdata[TIME_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.model <= MODEL_100MV;
      cfg_r.fb_en <= 1'b0;
      cfg_r.samples <= CNT_W'(1);
      cfg_r.interval <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcsa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_adc_input  (in_adc_input),
    .in_adc_supply (in_adc_supply),
    .in_now_ms     (in_now_ms),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  rcsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rcsa_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg_r),
    .q_valid                 (q_valid),
    .q_item                  (q_item),
    .q_pop                   (q_pop),
    .div_req                 (div_req),
    .div_rsp                 (div_rsp),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_averaged_current_ma (out_averaged_current_ma),
    .out_report_cause        (out_report_cause)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_req.start)
    else $error("divider start held for more than one cycle");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("front queue popped while empty");

endmodule

@@ sim/current_report_checker.sv @@
// Checker for the ratiometric current-sensor averager: watches the configuration,
// input and result channels, predicts each report and compares it field by field.
// Depends on rcsa_pkg for register indexes, action and cause codes and sensor constants.
module current_report_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_push,
  input  logic               in_full,
  input  logic               in_action,
  input  logic [9:0]         in_adc_input,
  input  logic [9:0]         in_adc_supply,
  input  logic [31:0]        in_now_ms,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [15:0] out_averaged_current_ma,
  input  logic               out_report_cause,
  output int                 mismatch_count,
  output int                 reports_pending
);
  import rcsa_pkg::*;

  typedef struct {
    logic signed [15:0] average_ma;
    logic               cause;
  } report_t;

  report_t            expected_reports[$];

  logic [1:0]         sensor_model;
  logic               feedback_on;
  logic [15:0]        block_length;
  logic [31:0]        interval_ms;

  logic [15:0]        block_count;
  int                 block_sum;
  logic signed [15:0] held_average;
  logic [31:0]        last_report_ms;

  task automatic note_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint sample_milliamps(input logic [9:0] reading,
                                              input logic [9:0] supply_reading);
    longint supply;
    longint k;
    longint diff;
    longint mag;
    longint q;
    supply = feedback_on ? longint'(supply_reading) : (longint'(1) << ADC_W);
    if (supply == 0) supply = 1;
    case (sensor_model)
      MODEL_100MV: k = longint'(K_MODEL0);
      MODEL_37MV:  k = longint'(K_MODEL1);
      default:     k = longint'(K_MODEL2);
    endcase
    diff = 2 * longint'(reading) - supply;
    mag = (diff < 0) ? -diff : diff;
    q = mag * k / supply;
    if (diff < 0) return -clamp(q, 0, 64'sd2147483648);
    return clamp(q, 0, 64'sd2147483647);
  endfunction

  task automatic predict_transaction(input logic action, input logic [9:0] reading,
                                     input logic [9:0] supply_reading, input logic [31:0] now);
    report_t r;
    longint  total;
    longint  n;
    logic [15:0] next_count;
    logic [31:0] deadline;
    if (action == ACTION_STATUS) begin
      r.average_ma = held_average;
      r.cause = CAUSE_STATUS;
      expected_reports.push_back(r);
      return;
    end
    total = clamp(longint'(block_sum) + sample_milliamps(reading, supply_reading),
                  -64'sd2147483648, 64'sd2147483647);
    block_sum = int'(total);
    n = (block_length == 16'd0) ? 1 : longint'(block_length);
    next_count = block_count + 16'd1;
    if (next_count == 16'd0 || longint'(next_count) >= n) begin
      held_average = 16'(clamp(total / n, -32768, 32767));
      block_count = 16'd0;
      block_sum = 0;
    end else begin
      block_count = next_count;
    end
    deadline = last_report_ms + interval_ms;
    if (now > deadline) begin
      last_report_ms = now;
      r.average_ma = held_average;
      r.cause = CAUSE_PERIODIC;
      expected_reports.push_back(r);
    end
  endtask

  initial begin
    mismatch_count = 0;
    reports_pending = 0;
  end

  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      expected_reports.delete();
      sensor_model = 2'd0;
      feedback_on = 1'b0;
      block_length = 16'd1;
      interval_ms = 32'd0;
      block_count = 16'd0;
      block_sum = 0;
      held_average = 16'sd0;
      last_report_ms = 32'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SENSOR_MODEL: sensor_model = cfg_wdata[1:0];
          CFG_FEEDBACK_EN:  feedback_on = cfg_wdata[0];
          CFG_SAMPLES:      block_length = cfg_wdata[15:0];
          CFG_INTERVAL:     interval_ms = cfg_wdata;
          default:          ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (expected_reports.size() == 0) begin
          note_mismatch($sformatf("unexpected report, average %0d cause %0d",
                                  out_averaged_current_ma, out_report_cause));
        end else begin
          want = expected_reports.pop_front();
          if (out_averaged_current_ma !== want.average_ma)
            note_mismatch($sformatf("averaged_current_ma got %0d expected %0d",
                                    out_averaged_current_ma, want.average_ma));
          if (out_report_cause !== want.cause)
            note_mismatch($sformatf("report_cause got %0d expected %0d",
                                    out_report_cause, want.cause));
        end
      end
      if (in_push && !in_full)
        predict_transaction(in_action, in_adc_input, in_adc_supply, in_now_ms);
    end
    reports_pending = expected_reports.size();
  end

endmodule

@@ sim/ratiometric_current_sensor_averager_unit_test.sv @@
// Testbench top for the ratiometric current-sensor averager: clock, reset, directed and
// random transactions, configuration phases and the verdict.
// Depends on rcsa_pkg, the block under test and current_report_checker.
module ratiometric_current_sensor_averager_unit_test;
  import rcsa_pkg::*;

  localparam logic [1:0] MODEL_18MV  = 2'd2;
  localparam logic [1:0] MODEL_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               in_push;
  logic               in_full;
  logic               in_action;
  logic [9:0]         in_adc_input;
  logic [9:0]         in_adc_supply;
  logic [31:0]        in_now_ms;
  logic               out_empty;
  logic               out_pop;
  logic signed [15:0] out_averaged_current_ma;
  logic               out_report_cause;
  int                 mismatch_count;
  int                 reports_pending;
  logic               calm;
  logic [31:0]        clock_ms;

  always #4 clk = ~clk;

  ratiometric_current_sensor_averager_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_push(in_push),
    .in_full(in_full),
    .in_action(in_action),
    .in_adc_input(in_adc_input),
    .in_adc_supply(in_adc_supply),
    .in_now_ms(in_now_ms),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_averaged_current_ma(out_averaged_current_ma),
    .out_report_cause(out_report_cause)
  );

  current_report_checker i_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_push(in_push),
    .in_full(in_full),
    .in_action(in_action),
    .in_adc_input(in_adc_input),
    .in_adc_supply(in_adc_supply),
    .in_now_ms(in_now_ms),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_averaged_current_ma(out_averaged_current_ma),
    .out_report_cause(out_report_cause),
    .mismatch_count(mismatch_count),
    .reports_pending(reports_pending)
  );

  task automatic push_item(input logic action, input logic [9:0] reading,
                           input logic [9:0] supply_reading, input logic [31:0] stamp);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_action <= action;
    in_adc_input <= reading;
    in_adc_supply <= supply_reading;
    in_now_ms <= stamp;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic sample_at(input logic [9:0] reading, input logic [9:0] supply_reading);
    clock_ms = clock_ms + 32'd1;
    push_item(ACTION_SAMPLE, reading, supply_reading, clock_ms);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic write_settings(input logic [1:0] model, input logic feedback,
                                input logic [15:0] block_length, input logic [31:0] interval);
    write_register(CFG_SENSOR_MODEL, {30'd0, model});
    write_register(CFG_FEEDBACK_EN, {31'd0, feedback});
    write_register(CFG_SAMPLES, {16'd0, block_length});
    write_register(CFG_INTERVAL, interval);
    cfg_we <= 1'b0;
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_pop <= 1'b1;
    end
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [1:0]  model;
    logic [15:0] block_length;
    logic [31:0] interval;
    logic [31:0] stamp;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SENSOR_MODEL;
    cfg_wdata = 32'd0;
    in_push = 1'b0;
    in_action = ACTION_SAMPLE;
    in_adc_input = 10'd0;
    in_adc_supply = 10'd0;
    in_now_ms = 32'd0;
    calm = 1'b0;
    clock_ms = 32'd0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: nominal supply, one sample per block, no report spacing.
    push_item(ACTION_STATUS, 10'd0, 10'd0, 32'd0);
    sample_at(10'd0, 10'd0);
    sample_at(10'd1023, 10'd0);
    push_item(ACTION_SAMPLE, 10'd512, 10'd0, clock_ms);
    push_item(ACTION_STATUS, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
    settle();

    // Spare sensor model, zero supply reading, zero block length, wrapping deadline.
    write_settings(MODEL_SPARE, 1'b1, 16'd0, 32'hFFFF_FFFF);
    push_item(ACTION_SAMPLE, 10'd1023, 10'd0, 32'hFFFF_FFFF);
    push_item(ACTION_SAMPLE, 10'd0, 10'd1023, 32'd5);
    push_item(ACTION_SAMPLE, 10'd1023, 10'd1023, 32'd0);
    push_item(ACTION_STATUS, 10'd0, 10'd0, 32'd0);
    settle();

    // Drive the running sum into saturation, then shorten the block mid-way.
    write_settings(MODEL_18MV, 1'b1, 16'hFFFF, 32'd0);
    for (int i = 0; i < 12; i++) sample_at(10'd1023, 10'd1);
    settle();
    write_settings(MODEL_37MV, 1'b1, 16'd2, 32'd0);
    sample_at(10'd700, 10'd600);
    push_item(ACTION_STATUS, 10'd0, 10'd0, 32'd0);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      model = 2'($urandom_range(0, 3));
      case (phase)
        2:       block_length = 16'hFFFF;
        5:       block_length = 16'($urandom_range(0, 65535));
        default: block_length = 16'($urandom_range(0, 6));
      endcase
      case ($urandom_range(0, 3))
        0:       interval = 32'd0;
        1:       interval = $urandom_range(0, 15);
        2:       interval = $urandom();
        default: interval = 32'hFFFF_FFFF;
      endcase
      if (phase == 0) model = MODEL_100MV;
      write_settings(model, 1'($urandom_range(0, 1)), block_length, interval);
      calm = (phase == 7);
      for (int i = 0; i < 50; i++) begin
        clock_ms = clock_ms + 32'($urandom_range(0, 12));
        stamp = ($urandom_range(0, 19) == 0) ? $urandom() : clock_ms;
        push_item($urandom_range(0, 4) == 0 ? ACTION_STATUS : ACTION_SAMPLE,
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), stamp);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ ratiometric_current_sensor_averager_unit.f @@
src/rcsa_pkg.sv
src/rcsa_front.sv
src/rcsa_div.sv
src/rcsa_back.sv
src/ratiometric_current_sensor_averager_unit.sv
sim/current_report_checker.sv
sim/ratiometric_current_sensor_averager_unit_test.sv
